/* rtl/core/pgcs_pkg.sv */
// Package for the PID gain candidate search: modes, operations, gain types and constants.
package pgcs_pkg;

  // Fixed-point and search constants
  localparam int unsigned FracBits   = 16;
  localparam int unsigned Candidates = 7;

  localparam logic [21:0] LimKp = 22'(50 << FracBits);
  localparam logic [21:0] LimKi = 22'(10 << FracBits);
  localparam logic [21:0] LimKd = 22'(20 << FracBits);

  // Steps of 0.10, 0.005 and 0.05, rounded to nearest
  localparam logic [19:0] StepKpReset = 20'(((1 << FracBits) + 5) / 10);
  localparam logic [19:0] StepKiReset = 20'(((1 << FracBits) + 100) / 200);
  localparam logic [19:0] StepKdReset = 20'(((1 << FracBits) + 10) / 20);

  typedef enum logic [2:0] {
    MODE_IDLE  = 3'd0,
    MODE_RUN   = 3'd1,
    MODE_WAIT  = 3'd2,
    MODE_DONE  = 3'd3,
    MODE_ABORT = 3'd4,
    MODE_ERROR = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    OP_START  = 3'd0,
    OP_SUBMIT = 3'd1,
    OP_STOP   = 3'd2,
    OP_APPLY  = 3'd3,
    OP_CLEAR  = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    REG_BASE_KP = 3'd0,
    REG_BASE_KI = 3'd1,
    REG_BASE_KD = 3'd2,
    REG_STEP_KP = 3'd3,
    REG_STEP_KI = 3'd4,
    REG_STEP_KD = 3'd5
  } reg_idx_e;

  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_UP   = 2'd1,
    DIR_DOWN = 2'd2
  } dir_e;

  typedef struct packed {
    logic [21:0] kp;
    logic [19:0] ki;
    logic [20:0] kd;
  } gains_t;

  // Perturbation direction of one gain (axis 0 kp, 1 ki, 2 kd) for a candidate.
  // Candidates 1 and 2 move kp up and down, 3 and 4 move ki, 5 and 6 move kd.
  function automatic dir_e cand_dir(input logic [2:0] idx, input logic [1:0] axis);
    dir_e d;
    d = DIR_NONE;
    if (idx != 3'd0 && ((idx - 3'd1) >> 1) == {1'b0, axis}) begin
      d = idx[0] ? DIR_UP : DIR_DOWN;
    end
    return d;
  endfunction

  // Adds or subtracts one step as dir says (no step for DIR_NONE) and clamps the result to 0..lim.
  function automatic logic [21:0] clamp_gain(input logic [21:0] base, input logic [19:0] step,
                                             input dir_e dir, input logic [21:0] lim);
    logic signed [23:0] sum;
    logic [21:0]        res;
    case (dir)
      DIR_UP:   sum = $signed({2'b00, base}) + $signed({4'b0000, step});
      DIR_DOWN: sum = $signed({2'b00, base}) - $signed({4'b0000, step});
      default:  sum = $signed({2'b00, base});
    endcase
    if (sum < 0) begin
      res = '0;
    end else if (sum > $signed({2'b00, lim})) begin
      res = lim;
    end else begin
      res = sum[21:0];
    end
    return res;
  endfunction

endpackage

/* rtl/core/pid_gain_candidate_search.sv */
// PID gain candidate search: sweeps seven gain sets around a base and keeps the best scorer.
//
// Usage. Configuration writes (index 0..2 base gains, 3..5 perturbation steps) arrive on the
// cfg channel, which is always ready; a step write of zero is dropped. They must be made while the
// block is idle; the block does not enforce this. Each beat on the input channel carries one
// operation (start, submit score, stop, apply best, clear) with the score and the sink and save
// flags. Every input beat gives exactly one result beat: the new tuner mode, whether the
// operation was accepted, the gain set offered to the sink (if any), and the search status.
// The result of a beat is registered and is valid from the cycle after the beat is taken.
// Throughput is one beat per cycle while the receiver does not stall; the whole operation is one
// clamp-and-compare step between the state registers and the result register.
// The result register decouples the two sides: a new beat is taken whenever the result
// register is empty or is being drained in the same cycle. While the receiver stalls, the
// result holds and the input is refused; beats are taken again from the cycle it is drained.
// Reset puts the block in idle with no best recorded and the default steps loaded.
module pid_gain_candidate_search
  import pgcs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [21:0] cfg_data_i,

  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  op_i,
  input  logic [31:0] score_i,
  input  logic        sink_accepts_i,
  input  logic        save_request_i,

  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  tuner_mode_o,
  output logic        accepted_o,
  output logic        gains_valid_o,
  output logic [21:0] out_kp_o,
  output logic [19:0] out_ki_o,
  output logic [20:0] out_kd_o,
  output logic        save_flag_o,
  output logic [2:0]  trial_number_o,
  output logic        have_best_o,
  output logic [31:0] top_score_o,
  output logic        active_o
);

  // Configuration registers
  gains_t      base_q;
  logic [19:0] step_kp_q, step_ki_q, step_kd_q;

  // Search state
  mode_e       mode_q, mode_d;
  logic [2:0]  trial_q, trial_d;
  gains_t      captured_q, captured_d;
  gains_t      trial_gains_q, trial_gains_d;
  gains_t      best_gains_q, best_gains_d;
  logic [31:0] best_score_q, best_score_d;
  logic        best_flag_q, best_flag_d;

  // Result register
  logic        out_valid_q;
  mode_e       res_mode_q;
  logic        res_acc_q, res_gv_q, res_sf_q, res_flag_q, res_active_q;
  gains_t      res_gains_q;
  logic [2:0]  res_trial_q;
  logic [31:0] res_score_q;

  // Combinational step results
  logic        in_take;
  logic        acc, gv, sf;
  gains_t      out_gains;
  gains_t      cand_base;
  gains_t      cand;
  logic [21:0] cand_kp_full, cand_ki_full, cand_kd_full;
  logic [2:0]  cand_idx;
  logic        last_trial;
  logic        better;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_take     = in_valid_i && in_ready_o;

  // Configuration writes; a zero step is ignored
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      step_kp_q <= StepKpReset;
      step_ki_q <= StepKiReset;
      step_kd_q <= StepKdReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_BASE_KP: base_q.kp <= cfg_data_i;
        REG_BASE_KI: base_q.ki <= cfg_data_i[19:0];
        REG_BASE_KD: base_q.kd <= cfg_data_i[20:0];
        REG_STEP_KP: if (cfg_data_i[19:0] != '0) step_kp_q <= cfg_data_i[19:0];
        REG_STEP_KI: if (cfg_data_i[19:0] != '0) step_ki_q <= cfg_data_i[19:0];
        REG_STEP_KD: if (cfg_data_i[19:0] != '0) step_kd_q <= cfg_data_i[19:0];
        default: ;
      endcase
    end
  end

  // Candidate to offer: the base on start, otherwise the next one after the current trial
  assign cand_idx     = (op_i == OP_START) ? 3'd0 : trial_q + 3'd1;
  assign cand_base    = (op_i == OP_START) ? base_q : captured_q;
  assign cand_kp_full = clamp_gain(cand_base.kp, step_kp_q, cand_dir(cand_idx, 2'd0), LimKp);
  assign cand_ki_full = clamp_gain({2'b00, cand_base.ki}, step_ki_q,
                                   cand_dir(cand_idx, 2'd1), LimKi);
  assign cand_kd_full = clamp_gain({1'b0, cand_base.kd}, step_kd_q,
                                   cand_dir(cand_idx, 2'd2), LimKd);
  assign cand         = '{kp: cand_kp_full, ki: cand_ki_full[19:0], kd: cand_kd_full[20:0]};
  assign last_trial   = ({1'b0, trial_q} + 4'd1) >= 4'(Candidates);
  assign better       = !best_flag_q || ($signed(score_i) > $signed(best_score_q));

  // Operation decode and next state
  always_comb begin
    mode_d        = mode_q;
    trial_d       = trial_q;
    captured_d    = captured_q;
    trial_gains_d = trial_gains_q;
    best_gains_d  = best_gains_q;
    best_score_d  = best_score_q;
    best_flag_d   = best_flag_q;
    acc           = 1'b0;
    gv            = 1'b0;
    sf            = 1'b0;
    out_gains     = '0;
    unique case (op_i)
      OP_START: begin
        trial_d      = '0;
        captured_d   = base_q;
        best_gains_d = '0;
        best_score_d = '0;
        best_flag_d  = 1'b0;
        if (sink_accepts_i) begin
          trial_gains_d = cand;
          out_gains     = cand;
          gv            = 1'b1;
          acc           = 1'b1;
          mode_d        = MODE_WAIT;
        end else begin
          trial_gains_d = base_q;
          mode_d        = MODE_ERROR;
        end
      end
      OP_SUBMIT: begin
        if (mode_q == MODE_WAIT) begin
          acc = 1'b1;
          if (better) begin
            best_gains_d = trial_gains_q;
            best_score_d = score_i;
            best_flag_d  = 1'b1;
          end
          if (last_trial) begin
            mode_d = MODE_DONE;
          end else if (sink_accepts_i) begin
            trial_gains_d = cand;
            trial_d       = cand_idx;
            out_gains     = cand;
            gv            = 1'b1;
            mode_d        = MODE_WAIT;
          end else begin
            mode_d = MODE_ERROR;
          end
        end
      end
      OP_STOP: begin
        if (mode_q != MODE_IDLE && mode_q != MODE_DONE) begin
          mode_d = MODE_ABORT;
          acc    = 1'b1;
        end
      end
      OP_APPLY: begin
        if (best_flag_q && sink_accepts_i) begin
          acc       = 1'b1;
          gv        = 1'b1;
          sf        = save_request_i;
          out_gains = best_gains_q;
        end
      end
      OP_CLEAR: begin
        mode_d        = MODE_IDLE;
        trial_d       = '0;
        captured_d    = '0;
        trial_gains_d = '0;
        best_gains_d  = '0;
        best_score_d  = '0;
        best_flag_d   = 1'b0;
        acc           = 1'b1;
      end
      default: ;
    endcase
  end

  // State registers and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_IDLE;
      trial_q       <= '0;
      captured_q    <= '0;
      trial_gains_q <= '0;
      best_gains_q  <= '0;
      best_score_q  <= '0;
      best_flag_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (in_take) begin
        mode_q        <= mode_d;
        trial_q       <= trial_d;
        captured_q    <= captured_d;
        trial_gains_q <= trial_gains_d;
        best_gains_q  <= best_gains_d;
        best_score_q  <= best_score_d;
        best_flag_q   <= best_flag_d;
        out_valid_q   <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload, loaded with each accepted beat
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      res_mode_q   <= mode_d;
      res_acc_q    <= acc;
      res_gv_q     <= gv;
      res_gains_q  <= out_gains;
      res_sf_q     <= sf;
      res_trial_q  <= trial_d;
      res_flag_q   <= best_flag_d;
      res_score_q  <= best_score_d;
      res_active_q <= (mode_d == MODE_WAIT) || (mode_d == MODE_RUN);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign tuner_mode_o   = res_mode_q;
  assign accepted_o     = res_acc_q;
  assign gains_valid_o  = res_gv_q;
  assign out_kp_o       = res_gains_q.kp;
  assign out_ki_o       = res_gains_q.ki;
  assign out_kd_o       = res_gains_q.kd;
  assign save_flag_o    = res_sf_q;
  assign trial_number_o = res_trial_q;
  assign have_best_o    = res_flag_q;
  assign top_score_o    = res_score_q;
  assign active_o       = res_active_q;

endmodule

/* tb/pid_gain_candidate_search_tb.sv */
// Self-checking testbench for the PID gain candidate search block.
module pid_gain_candidate_search_tb;
  import pgcs_pkg::*;

  // Run controls
  localparam int          ItemsPerPhase = 245;
  localparam int          LongHoldAt    = 400;
  localparam int          LongHoldLen   = 200;
  localparam int          SettleCycles  = 4;
  localparam int          PrintLimit    = 200;
  localparam logic [2:0]  RegSpareA     = 3'd6;
  localparam logic [2:0]  RegSpareB     = 3'd7;
  localparam logic [2:0]  OpSpare       = 3'd7;
  localparam logic [31:0] ScoreMin      = 32'h8000_0000;
  localparam logic [31:0] ScoreMax      = 32'h7FFF_FFFF;

  typedef struct {
    logic [2:0]  op;
    logic [31:0] score;
    logic        sink;
    logic        save;
  } gain_op_t;

  typedef struct {
    logic [2:0]  mode;
    logic        accepted;
    logic        gains_valid;
    logic [21:0] kp;
    logic [19:0] ki;
    logic [20:0] kd;
    logic        save;
    logic [2:0]  trial;
    logic        have_best;
    logic [31:0] top;
    logic        active;
  } outcome_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [21:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [2:0]  op = '0;
  logic [31:0] score = '0;
  logic        sink_accepts = 1'b0;
  logic        save_request = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  tuner_mode;
  logic        accepted;
  logic        gains_valid;
  logic [21:0] out_kp;
  logic [19:0] out_ki;
  logic [20:0] out_kd;
  logic        save_flag;
  logic [2:0]  trial_number;
  logic        have_best;
  logic [31:0] top_score;
  logic        active;

  pid_gain_candidate_search u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .op_i           (op),
    .score_i        (score),
    .sink_accepts_i (sink_accepts),
    .save_request_i (save_request),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .tuner_mode_o   (tuner_mode),
    .accepted_o     (accepted),
    .gains_valid_o  (gains_valid),
    .out_kp_o       (out_kp),
    .out_ki_o       (out_ki),
    .out_kd_o       (out_kd),
    .save_flag_o    (save_flag),
    .trial_number_o (trial_number),
    .have_best_o    (have_best),
    .top_score_o    (top_score),
    .active_o       (active)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  gain_op_t ops_queued[$];
  outcome_t outcomes_due[$];
  int ops_sent     = 0;
  int ops_taken    = 0;
  int results_seen = 0;
  int cfg_writes   = 0;
  int settings_run = 0;
  int fault_count  = 0;

  // Shadow copy of the search state and the configuration registers.
  logic [21:0] base_cfg [3];
  logic [19:0] step_cfg [3];
  logic [21:0] cap_base [3];
  logic [21:0] trial_g  [3];
  logic [21:0] best_g   [3];
  logic [21:0] offered  [3];
  mode_e       md;
  logic [2:0]  trial;
  logic [31:0] best_sc;
  logic        best_seen;

  task automatic report_fault(input string msg);
    if (fault_count < PrintLimit) $display("ERROR at %0t: %s", $realtime, msg);
    fault_count++;
  endtask

  task automatic check_field(input string name, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      report_fault($sformatf("result %0d field %s is 0x%0h, expected 0x%0h",
                             results_seen, name, got, want));
    end
  endtask

  function automatic logic [21:0] gain_limit(input int axis);
    case (axis)
      0:       return LimKp;
      1:       return LimKi;
      default: return LimKd;
    endcase
  endfunction

  // One gain of a candidate: base moved by one step on its axis, then clamped.
  function automatic logic [21:0] candidate_gain(input logic [2:0] idx, input int axis,
                                                 input logic [21:0] b, input logic [19:0] s);
    longint v;
    v = longint'(b);
    if (idx != 3'd0 && (int'(idx) - 1) / 2 == axis) begin
      v = idx[0] ? v + longint'(s) : v - longint'(s);
    end
    if (v < 0) v = 0;
    if (v > longint'(gain_limit(axis))) v = longint'(gain_limit(axis));
    return v[21:0];
  endfunction

  task automatic clear_search();
    md        = MODE_IDLE;
    trial     = '0;
    best_sc   = '0;
    best_seen = 1'b0;
    for (int a = 0; a < 3; a++) begin
      trial_g[a]  = '0;
      best_g[a]   = '0;
      cap_base[a] = '0;
    end
  endtask

  // Offers a candidate to the sink; a refusal puts the search in error.
  task automatic present_trial(input logic [2:0] idx, input logic sink, output logic gv);
    logic [21:0] nxt [3];
    for (int a = 0; a < 3; a++) nxt[a] = candidate_gain(idx, a, cap_base[a], step_cfg[a]);
    if (!sink) begin
      md = MODE_ERROR;
      gv = 1'b0;
    end else begin
      trial_g = nxt;
      offered = nxt;
      trial   = idx;
      md      = MODE_WAIT;
      gv      = 1'b1;
    end
  endtask

  task automatic note_cfg(input logic [2:0] idx, input logic [21:0] d);
    case (idx)
      REG_BASE_KP: base_cfg[0] = d;
      REG_BASE_KI: base_cfg[1] = {2'b00, d[19:0]};
      REG_BASE_KD: base_cfg[2] = {1'b0, d[20:0]};
      REG_STEP_KP: if (d[19:0] != '0) step_cfg[0] = d[19:0];
      REG_STEP_KI: if (d[19:0] != '0) step_cfg[1] = d[19:0];
      REG_STEP_KD: if (d[19:0] != '0) step_cfg[2] = d[19:0];
      default: ;
    endcase
  endtask

  // Works out the result beat that one operation beat must produce.
  task automatic search_step(input gain_op_t it, output outcome_t r);
    logic acc, gv, sf;
    acc = 1'b0;
    gv  = 1'b0;
    sf  = 1'b0;
    for (int a = 0; a < 3; a++) offered[a] = '0;
    case (it.op)
      OP_START: begin
        clear_search();
        for (int a = 0; a < 3; a++) begin
          cap_base[a] = base_cfg[a];
          trial_g[a]  = base_cfg[a];
        end
        md = MODE_RUN;
        present_trial(3'd0, it.sink, gv);
        acc = (md == MODE_WAIT);
      end
      OP_SUBMIT: begin
        if (md == MODE_WAIT) begin
          acc = 1'b1;
          if (!best_seen || $signed(it.score) > $signed(best_sc)) begin
            best_g    = trial_g;
            best_sc   = it.score;
            best_seen = 1'b1;
          end
          if (int'(trial) + 1 >= Candidates) begin
            md = MODE_DONE;
          end else begin
            md = MODE_RUN;
            present_trial(trial + 3'd1, it.sink, gv);
          end
        end
      end
      OP_STOP: begin
        if (md != MODE_IDLE && md != MODE_DONE) begin
          md  = MODE_ABORT;
          acc = 1'b1;
        end
      end
      OP_APPLY: begin
        if (best_seen && it.sink) begin
          acc     = 1'b1;
          gv      = 1'b1;
          sf      = it.save;
          offered = best_g;
        end
      end
      OP_CLEAR: begin
        clear_search();
        acc = 1'b1;
      end
      default: ;
    endcase
    r.mode        = md;
    r.accepted    = acc;
    r.gains_valid = gv;
    r.kp          = gv ? offered[0] : '0;
    r.ki          = gv ? offered[1][19:0] : '0;
    r.kd          = gv ? offered[2][20:0] : '0;
    r.save        = sf;
    r.trial       = trial;
    r.have_best   = best_seen;
    r.top         = best_sc;
    r.active      = (md == MODE_RUN || md == MODE_WAIT);
  endtask

  // Idle gaps: mostly none, some short, a few long.
  function automatic int draw_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 78) return 0;
    if (r < 96) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Operation beats are offered at the falling edge and held until taken.
  int feed_gap  = 0;
  int feed_calm = 0;
  always @(negedge clk) begin : feed_ops
    gain_op_t nxt;
    if (rst_n && (!in_valid || ops_taken == ops_sent)) begin
      if (feed_gap != 0) begin
        feed_gap--;
        in_valid <= 1'b0;
      end else if (ops_queued.size() != 0) begin
        nxt = ops_queued.pop_front();
        in_valid     <= 1'b1;
        op           <= nxt.op;
        score        <= nxt.score;
        sink_accepts <= nxt.sink;
        save_request <= nxt.save;
        ops_sent++;
        if (feed_calm != 0) begin
          feed_calm--;
        end else begin
          feed_gap = draw_gap();
          if ($urandom_range(0, 199) == 0) feed_calm = 60;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // The receiver stalls at random and once holds off for a long stretch.
  int  drain_hold = 0;
  int  drain_calm = 0;
  bit  long_hold_done = 1'b0;
  always @(negedge clk) begin : drain_results
    if (rst_n) begin
      if (!long_hold_done && ops_taken >= LongHoldAt) begin
        drain_hold     = LongHoldLen;
        long_hold_done = 1'b1;
      end
      if (drain_hold != 0) begin
        drain_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (drain_calm != 0) begin
          drain_calm--;
        end else begin
          drain_hold = draw_gap();
          if ($urandom_range(0, 199) == 0) drain_calm = 60;
        end
      end
    end
  end

  // Both channels are sampled at the rising edge; predictions go in before checks.
  always @(posedge clk) begin : watch_ports
    gain_op_t seen;
    outcome_t due;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        seen.op    = op;
        seen.score = score;
        seen.sink  = sink_accepts;
        seen.save  = save_request;
        search_step(seen, due);
        outcomes_due.push_back(due);
        ops_taken++;
      end
      if (out_valid && out_ready) begin
        if (outcomes_due.size() == 0) begin
          report_fault("result beat arrived with nothing expected");
        end else begin
          due = outcomes_due.pop_front();
          check_field("tuner_mode", 32'(tuner_mode), 32'(due.mode));
          check_field("accepted", 32'(accepted), 32'(due.accepted));
          check_field("gains_valid", 32'(gains_valid), 32'(due.gains_valid));
          check_field("out_kp", 32'(out_kp), 32'(due.kp));
          check_field("out_ki", 32'(out_ki), 32'(due.ki));
          check_field("out_kd", 32'(out_kd), 32'(due.kd));
          check_field("save_flag", 32'(save_flag), 32'(due.save));
          check_field("trial_number", 32'(trial_number), 32'(due.trial));
          check_field("have_best", 32'(have_best), 32'(due.have_best));
          check_field("top_score", top_score, due.top);
          check_field("active", 32'(active), 32'(due.active));
        end
        results_seen++;
      end
    end
  end

  task automatic queue_op(input logic [2:0] o, input logic [31:0] sc, input logic snk,
                          input logic sv);
    gain_op_t it;
    it.op    = o;
    it.score = sc;
    it.sink  = snk;
    it.save  = sv;
    ops_queued.push_back(it);
  endtask

  task automatic cfg_write(input logic [2:0] idx, input logic [21:0] d);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    note_cfg(idx, d);
    cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_setting(input logic [21:0] bkp, input logic [21:0] bki,
                              input logic [21:0] bkd, input logic [21:0] skp,
                              input logic [21:0] ski, input logic [21:0] skd);
    cfg_write(REG_BASE_KP, bkp);
    cfg_write(REG_BASE_KI, bki);
    cfg_write(REG_BASE_KD, bkd);
    cfg_write(REG_STEP_KP, skp);
    cfg_write(REG_STEP_KI, ski);
    cfg_write(REG_STEP_KD, skd);
    settings_run++;
  endtask

  // Waits until every queued beat has been taken and every result has come back.
  task automatic wait_for_quiet();
    while (ops_queued.size() != 0 || in_valid || outcomes_due.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Scores lean towards the extremes and towards ties with the previous one.
  function automatic logic [31:0] draw_score(input logic [31:0] prev);
    case ($urandom_range(0, 9))
      0:       return ScoreMin;
      1:       return ScoreMax;
      2, 3:    return prev;
      4:       return 32'($signed($urandom_range(0, 4000)) - 2000);
      default: return $urandom;
    endcase
  endfunction

  // Mostly complete sweeps with random content, with noise and broken sweeps mixed in.
  task automatic queue_random_items(input int n);
    int          count;
    int          r;
    logic [31:0] prev;
    logic [31:0] s;
    count = 0;
    prev  = '0;
    while (count < n) begin
      r = $urandom_range(0, 99);
      if (r < 80) begin
        queue_op(OP_START, $urandom, $urandom_range(0, 15) != 0, 1'($urandom));
        count++;
        for (int k = 0; k < Candidates; k++) begin
          if ($urandom_range(0, 39) == 0) begin
            queue_op(3'($urandom_range(0, 7)), $urandom, 1'($urandom), 1'($urandom));
          end
          if ($urandom_range(0, 49) == 0) begin
            queue_op(OP_STOP, $urandom, 1'($urandom), 1'($urandom));
            count++;
            break;
          end
          s    = draw_score(prev);
          prev = s;
          queue_op(OP_SUBMIT, s, $urandom_range(0, 19) != 0, 1'($urandom));
          count++;
        end
        if ($urandom_range(0, 3) != 0) begin
          queue_op(OP_APPLY, $urandom, $urandom_range(0, 3) != 0, 1'($urandom));
          count++;
        end
        if ($urandom_range(0, 9) == 0) begin
          queue_op(OP_SUBMIT, draw_score(prev), 1'($urandom), 1'($urandom));
        end
      end else if (r < 90) begin
        queue_op(3'($urandom_range(0, 7)), $urandom, 1'($urandom), 1'($urandom));
        count++;
      end else if (r < 95) begin
        queue_op(OP_CLEAR, $urandom, 1'($urandom), 1'($urandom));
        count++;
      end else begin
        queue_op(OP_STOP, $urandom, 1'($urandom), 1'($urandom));
        count++;
      end
    end
  endtask

  initial begin : watchdog
    #3000000;
    $display("status: fail");
    $finish;
  end

  initial begin : run_test
    // Shadow state after reset: base gains zero, default steps.
    for (int a = 0; a < 3; a++) base_cfg[a] = '0;
    step_cfg[0] = StepKpReset;
    step_cfg[1] = StepKiReset;
    step_cfg[2] = StepKdReset;
    clear_search();

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed sweep at the reset setting: refusals, ties and score extremes.
    queue_op(OP_APPLY, '0, 1'b1, 1'b0);
    queue_op(OP_SUBMIT, 32'd5, 1'b1, 1'b0);
    queue_op(OP_STOP, '0, 1'b1, 1'b0);
    queue_op(OP_START, '0, 1'b1, 1'b0);
    queue_op(OP_SUBMIT, ScoreMin, 1'b1, 1'b0);
    queue_op(OP_SUBMIT, ScoreMin, 1'b1, 1'b0);
    queue_op(OP_SUBMIT, ScoreMax, 1'b1, 1'b1);
    queue_op(OP_SUBMIT, '0, 1'b1, 1'b0);
    queue_op(OP_SUBMIT, ScoreMax, 1'b1, 1'b0);
    queue_op(OP_SUBMIT, '1, 1'b1, 1'b0);
    queue_op(OP_SUBMIT, 32'd1, 1'b1, 1'b0);
    queue_op(OP_SUBMIT, ScoreMax, 1'b1, 1'b0);
    queue_op(OP_STOP, '0, 1'b1, 1'b0);
    queue_op(OP_APPLY, '0, 1'b0, 1'b1);
    queue_op(OP_APPLY, '1, 1'b1, 1'b1);
    queue_op(OpSpare, '1, 1'b1, 1'b1);
    queue_op(OP_CLEAR, '0, 1'b0, 1'b0);
    wait_for_quiet();

    // Bases above their limits; zero step writes and spare indexes must be dropped.
    cfg_write(REG_BASE_KP, '1);
    cfg_write(REG_BASE_KI, '1);
    cfg_write(REG_BASE_KD, '1);
    cfg_write(REG_STEP_KP, '0);
    cfg_write(REG_STEP_KI, 22'h10_0000);
    cfg_write(REG_STEP_KD, '0);
    cfg_write(RegSpareA, '1);
    cfg_write(RegSpareB, 22'h15_5555);

    // Error and abort paths, then a clamped base sweep refused part way.
    queue_op(OP_START, '0, 1'b0, 1'b0);
    queue_op(OP_SUBMIT, 32'd7, 1'b1, 1'b0);
    queue_op(OP_STOP, '0, 1'b1, 1'b0);
    queue_op(OP_STOP, '0, 1'b1, 1'b0);
    queue_op(OP_START, '0, 1'b1, 1'b0);
    queue_op(OP_SUBMIT, 32'h0001_0000, 1'b0, 1'b0);
    queue_op(OP_APPLY, '0, 1'b1, 1'b0);
    wait_for_quiet();

    // Random sweeps under several settings, extremes first.
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: load_setting('0, '0, '0, 22'hF_FFFF, 22'hF_FFFF, 22'hF_FFFF);
        1: load_setting(LimKp, LimKi, LimKd, 22'd1, 22'd1, 22'd1);
        2: load_setting(22'($urandom_range(0, LimKp)), 22'($urandom_range(0, LimKi)),
                        22'($urandom_range(0, LimKd)), 22'($urandom_range(1, 655360)),
                        22'($urandom_range(1, 655360)), 22'($urandom_range(1, 655360)));
        3: load_setting(22'($urandom), 22'($urandom), 22'($urandom),
                        22'($urandom), 22'($urandom), 22'($urandom));
        default: load_setting(22'($urandom_range(0, LimKp)), 22'($urandom_range(0, LimKi)),
                              22'($urandom_range(0, LimKd)), 22'(StepKpReset),
                              22'(StepKiReset), 22'(StepKdReset));
      endcase
      queue_random_items(ItemsPerPhase);
      wait_for_quiet();
    end

    $display("Run covered %0d operation beats and %0d register writes over %0d settings.",
             ops_taken, cfg_writes, settings_run);
    $display("%0d result beats compared, %0d faults found.", results_seen, fault_count);
    if (fault_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/core/pgcs_pkg.sv
rtl/core/pid_gain_candidate_search.sv
tb/pid_gain_candidate_search_tb.sv
